// ===== design/cle_pkg.sv =====
// Package for the console line editor: character codes, item kinds and result record.
`default_nettype none

package cle_pkg;

    localparam logic [7:0] CH_EOT = 8'd4;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;

    localparam logic [6:0] LIMIT_RESET = 7'd64;

    localparam logic [1:0] K_EOT = 2'd0;
    localparam logic [1:0] K_BS  = 2'd1;
    localparam logic [1:0] K_NL  = 2'd2;
    localparam logic [1:0] K_CHR = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       done;
        logic [6:0] len;
    } t_step;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       store_valid;
        logic [5:0] store_index;
        logic [7:0] store_char;
        logic       line_done;
        logic [6:0] line_length;
        logic       last;
    } t_result;

    // Index of the final result that one input of this kind produces.
    function automatic logic [1:0] last_slot(logic [1:0] kind);
        logic [1:0] s;
        case (kind)
            K_BS:    s = 2'd2;
            K_NL:    s = 2'd1;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic t_result make_result(logic [1:0] kind, logic [1:0] slot,
                                            logic [7:0] ch, logic [5:0] idx,
                                            logic done, logic [6:0] len);
        t_result r;
        r = '0;
        if (slot == 2'd0) begin
            r.store_valid = 1'b1;
            r.store_index = idx;
            r.store_char  = ch;
        end
        case (kind)
            K_EOT: begin
                r.echo_valid = 1'b0;
            end
            K_BS: begin
                r.echo_valid = 1'b1;
                r.echo_char  = (slot == 2'd1) ? CH_SP : CH_BS;
            end
            K_NL: begin
                r.echo_valid = 1'b1;
                r.echo_char  = (slot == 2'd0) ? CH_CR : CH_LF;
            end
            default: begin
                r.echo_valid = 1'b1;
                r.echo_char  = ch;
            end
        endcase
        r.last = (slot == last_slot(kind));
        if (r.last && done) begin
            r.line_done   = 1'b1;
            r.line_length = len;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/cle_if.sv =====
// Valid/ready channel interfaces for received characters and editor results.
`default_nettype none

interface cle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface cle_out_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_char;
    logic       line_done;
    logic [6:0] line_length;
    logic       last;

    modport source (output valid, output echo_valid, output echo_char, output store_valid,
                    output store_index, output store_char, output line_done,
                    output line_length, output last, input ready);
    modport sink   (input valid, input echo_valid, input echo_char, input store_valid,
                    input store_index, input store_char, input line_done,
                    input line_length, input last, output ready);
endinterface

`default_nettype wire

// ===== design/console_line_editor_top.sv =====
// Top level of the cooked-mode console line editor.
//
//  Channel    Direction  Payload                                   Handshake
//  i_rx       in         rx_char                                   valid/ready
//  o_res      out        echo, store, line_done/length, last       valid/ready
//  i_cfg_*    in         line_limit (7 bits)                       write enable
//
// A character is decoded and the line position updated in the cycle it is accepted.
// It then emits one result per cycle while o_res is ready: one for EOT or plain char,
// two for CR/LF, three for backspace; pending slot and output register set the rate.
// A new character is taken in the cycle its last result moves to the output register.
// Reset clears the position, the limit (to 64) and both pending/output valid flags.
// A stalled output holds its result and, once the pending slot fills, stalls input.
`default_nettype none

module console_line_editor_top #(
    parameter int LINE_MAX = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    cle_in_if.sink          i_rx,
    cle_out_if.source       o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_data
);
    import cle_pkg::*;

    localparam int PW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

    logic [6:0]    r_limit;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    t_step         step;

    logic          r_pend_valid;
    logic [1:0]    r_pend_kind;
    logic [1:0]    r_pend_slot;
    logic [7:0]    r_pend_char;
    logic [PW-1:0] r_pend_pos;
    logic          r_pend_done;
    logic [6:0]    r_pend_len;

    t_result       r_out;
    logic          r_out_valid;
    t_result       n_out;

    logic          out_load;
    logic          pend_last;
    logic          in_take;

    cle_step #(.LINE_MAX(LINE_MAX)) u_step (
        .i_char     (i_rx.rx_char),
        .i_pos      (r_pos),
        .i_limit    (r_limit),
        .o_step     (step),
        .o_next_pos (n_pos)
    );

    assign out_load  = r_pend_valid && (!r_out_valid || o_res.ready);
    assign pend_last = (r_pend_slot == last_slot(r_pend_kind));
    assign i_rx.ready = !r_pend_valid || (out_load && pend_last);
    assign in_take   = i_rx.valid && i_rx.ready;

    assign n_out = make_result(r_pend_kind, r_pend_slot, r_pend_char, 6'(r_pend_pos),
                               r_pend_done, r_pend_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_pend_slot  <= 2'd0;
        end else begin
            if (in_take) begin
                r_pos        <= n_pos;
                r_pend_valid <= 1'b1;
                r_pend_slot  <= 2'd0;
            end else if (out_load) begin
                if (pend_last) begin
                    r_pend_valid <= 1'b0;
                end else begin
                    r_pend_slot <= r_pend_slot + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pend_kind <= step.kind;
            r_pend_char <= i_rx.rx_char;
            r_pend_pos  <= r_pos;
            r_pend_done <= step.done;
            r_pend_len  <= step.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.echo_valid  = r_out.echo_valid;
    assign o_res.echo_char   = r_out.echo_char;
    assign o_res.store_valid = r_out.store_valid;
    assign o_res.store_index = r_out.store_index;
    assign o_res.store_char  = r_out.store_char;
    assign o_res.line_done   = r_out.line_done;
    assign o_res.line_length = r_out.line_length;
    assign o_res.last        = r_out.last;

    // Only backspace and CR/LF requests walk past their first result.
    a_slot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_pend_slot != 2'd0) |-> (r_pend_kind == K_BS || r_pend_kind == K_NL))
        else $error("pending slot beyond first result for single-result kind");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pend_slot <= last_slot(r_pend_kind)))
        else $error("pending slot past last result");

    a_line_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && step.done) |=> (r_pos == '0))
        else $error("position not cleared after line end");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.line_done) |-> r_out.last)
        else $error("line_done on a result that is not last");

    a_store_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_pend_slot == 2'd0) |=> r_out.store_valid)
        else $error("first result of a request does not store");

endmodule

`default_nettype wire

// ===== design/cle_step.sv =====
// Per-character decode: item kind, line end, reported length and next position.
`default_nettype none

module cle_step #(
    parameter int LINE_MAX = 64,
    localparam int PW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
    input  wire logic [7:0]    i_char,
    input  wire logic [PW-1:0] i_pos,
    input  wire logic [6:0]    i_limit,
    output cle_pkg::t_step     o_step,
    output logic [PW-1:0]      o_next_pos
);
    import cle_pkg::*;

    localparam int CW = (PW + 1 > 7) ? PW + 1 : 7;

    logic [CW-1:0] lim;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] nxt;

    assign pos_ext = CW'(i_pos);
    assign nxt     = pos_ext + CW'(1);

    // Limit register values outside 1..LINE_MAX are clamped.
    always_comb begin
        lim = CW'(i_limit);
        if (lim == '0) begin
            lim = CW'(1);
        end else if (lim > CW'(LINE_MAX)) begin
            lim = CW'(LINE_MAX);
        end
    end

    always_comb begin
        o_step     = '0;
        o_next_pos = '0;
        if (i_char == CH_EOT) begin
            o_step.kind = K_EOT;
            o_step.done = 1'b1;
            o_step.len  = 7'(pos_ext);
        end else if (i_char == CH_BS) begin
            o_step.kind = K_BS;
            o_next_pos  = (i_pos != '0) ? (i_pos - PW'(1)) : i_pos;
        end else if (i_char == CH_CR || i_char == CH_LF) begin
            o_step.kind = K_NL;
            o_step.done = 1'b1;
            o_step.len  = 7'(nxt);
        end else begin
            o_step.kind = K_CHR;
            if (nxt >= lim) begin
                o_step.done = 1'b1;
                o_step.len  = 7'(nxt);
            end else begin
                o_next_pos = PW'(nxt);
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/console_line_editor_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the console line editor: a request table, then random lines.
module console_line_editor_top_tb;
    import cle_pkg::*;

    localparam int LINE_MAX    = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 10;
    localparam int HOLD_CYCLES = 120;
    localparam int N_PHASES    = 7;

    // One row of the request table; n_typed of zero means the predictor supplies the results.
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] n_typed;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;

    cle_in_if  rx_if ();
    cle_out_if res_if ();

    console_line_editor_top #(
        .LINE_MAX(LINE_MAX)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (rx_if),
        .o_res     (res_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    logic [6:0] phase_limit [N_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd17};
    int         phase_items [N_PHASES] = '{90, 40, 30, 70, 50, 90, 70};

    t_result    echo_q [$];
    t_result    pred_buf [3];
    int         cur_pos = 0;
    int         cur_limit = LIMIT_RESET;
    int         run_left = 0;
    int         n_err = 0;
    int         cyc = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result result_of(bit ev, logic [7:0] ec, bit sv, int si,
                                          logic [7:0] sc, bit ld, int ll, bit lst);
        t_result r;
        r = '0;
        r.echo_valid  = ev;
        r.store_valid = sv;
        r.line_done   = ld;
        r.last        = lst;
        if (ev) begin
            r.echo_char = ec;
        end
        if (sv) begin
            r.store_index = 6'(si);
            r.store_char  = sc;
        end
        if (ld) begin
            r.line_length = 7'(ll);
        end
        return r;
    endfunction

    // Edits the line with one character, fills pred_buf and returns how many results it gives.
    function automatic int predict_char(logic [7:0] ch);
        int lim;
        int pos;
        int cnt;
        lim = cur_limit;
        if (lim < 1) lim = 1;
        if (lim > LINE_MAX) lim = LINE_MAX;
        pos = cur_pos;
        cnt = 1;
        if (ch == CH_EOT) begin
            pred_buf[0] = result_of(0, 0, 1, pos, ch, 1, pos, 1);
            cur_pos = 0;
        end else if (ch == CH_BS) begin
            pred_buf[0] = result_of(1, CH_BS, 1, pos, ch, 0, 0, 0);
            pred_buf[1] = result_of(1, CH_SP, 0, 0, 0, 0, 0, 0);
            pred_buf[2] = result_of(1, CH_BS, 0, 0, 0, 0, 0, 1);
            if (pos != 0) cur_pos = pos - 1;
            cnt = 3;
        end else if (ch == CH_CR || ch == CH_LF) begin
            pred_buf[0] = result_of(1, CH_CR, 1, pos, ch, 0, 0, 0);
            pred_buf[1] = result_of(1, CH_LF, 0, 0, 0, 1, pos + 1, 1);
            cur_pos = 0;
            cnt = 2;
        end else if (pos + 1 >= lim) begin
            pred_buf[0] = result_of(1, ch, 1, pos, ch, 1, pos + 1, 1);
            cur_pos = 0;
        end else begin
            pred_buf[0] = result_of(1, ch, 1, pos, ch, 0, 0, 1);
            cur_pos = pos + 1;
        end
        return cnt;
    endfunction

    // Mostly printable runs of random length, each closed by CR, LF, EOT, BS or a random byte.
    function automatic logic [7:0] next_char();
        int         r;
        logic [7:0] c;
        if (run_left == 0) begin
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 70)
                                                   : $urandom_range(0, 12);
            r = $urandom_range(0, 4);
            case (r)
                0: c = CH_CR;
                1: c = CH_LF;
                2: c = CH_EOT;
                3: c = CH_BS;
                default: c = 8'($urandom_range(0, 255));
            endcase
        end else begin
            run_left--;
            r = $urandom_range(0, 19);
            if (r == 0) c = CH_BS;
            else if (r == 1) c = 8'($urandom_range(0, 255));
            else c = 8'($urandom_range(32, 126));
        end
        return c;
    endfunction

    task automatic send(t_dir_row row);
        int cnt;
        int gap;
        @(negedge i_clk);
        rx_if.valid   <= 1'b1;
        rx_if.rx_char <= row.ch;
        do @(posedge i_clk); while (!rx_if.ready);
        // The request is taken at this edge, so the line state moves on here.
        cnt = predict_char(row.ch);
        if (row.n_typed != 0) begin
            echo_q.push_back(row.r0);
            if (row.n_typed > 1) echo_q.push_back(row.r1);
            if (row.n_typed > 2) echo_q.push_back(row.r2);
        end else begin
            for (int k = 0; k < cnt; k++) echo_q.push_back(pred_buf[k]);
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            rx_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (echo_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_line_limit(logic [6:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        cur_limit = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_dir_row dir_tab [$];
        t_dir_row row;
        rx_if.valid   = 1'b0;
        rx_if.rx_char = 8'h00;
        i_cfg_we      = 1'b0;
        i_cfg_data    = 7'd0;
        i_rst_n       = 1'b0;

        dir_tab.push_back('{CH_EOT, 2'd1, result_of(0, 0, 1, 0, CH_EOT, 1, 0, 1), '0, '0});
        // Backspace at the start of a line still echoes all three bytes.
        dir_tab.push_back('{CH_BS, 2'd3, result_of(1, CH_BS, 1, 0, CH_BS, 0, 0, 0),
                            result_of(1, CH_SP, 0, 0, 0, 0, 0, 0),
                            result_of(1, CH_BS, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{CH_LF, 2'd2, result_of(1, CH_CR, 1, 0, CH_LF, 0, 0, 0),
                            result_of(1, CH_LF, 0, 0, 0, 1, 1, 1), '0});
        dir_tab.push_back('{CH_CR, 2'd2, result_of(1, CH_CR, 1, 0, CH_CR, 0, 0, 0),
                            result_of(1, CH_LF, 0, 0, 0, 1, 1, 1), '0});
        dir_tab.push_back('{8'h41, 2'd1, result_of(1, 8'h41, 1, 0, 8'h41, 0, 0, 1), '0, '0});
        dir_tab.push_back('{8'h00, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'hFF, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h80, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h7F, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h55, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'hAA, 2'd0, '0, '0, '0});
        dir_tab.push_back('{CH_BS, 2'd0, '0, '0, '0});
        dir_tab.push_back('{CH_BS, 2'd0, '0, '0, '0});
        dir_tab.push_back('{CH_CR, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h68, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h69, 2'd0, '0, '0, '0});
        dir_tab.push_back('{CH_EOT, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h01, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h09, 2'd0, '0, '0, '0});
        dir_tab.push_back('{8'h1B, 2'd0, '0, '0, '0});
        dir_tab.push_back('{CH_LF, 2'd0, '0, '0, '0});
        dir_tab.push_back('{CH_BS, 2'd0, '0, '0, '0});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send(dir_tab[i]);

        // A phase usually ends mid-line, so a lower limit often meets a position past it.
        for (int p = 0; p < N_PHASES; p++) begin
            set_line_limit(phase_limit[p]);
            quiet = (p == N_PHASES - 1);
            for (int k = 0; k < phase_items[p]; k++) begin
                if (p == 0 && k == 30) hold_req = 1'b1;
                if (p == 3 && k == 35) drain();
                row    = '0;
                row.ch = next_char();
                send(row);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_err == 0 && echo_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
            end
        end
    end

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.echo_valid  = res_if.echo_valid;
            got.echo_char   = res_if.echo_char;
            got.store_valid = res_if.store_valid;
            got.store_index = res_if.store_index;
            got.store_char  = res_if.store_char;
            got.line_done   = res_if.line_done;
            got.line_length = res_if.line_length;
            got.last        = res_if.last;
            if (echo_q.size() == 0) begin
                $error("unexpected result: echo_char %0h store_char %0h",
                       got.echo_char, got.store_char);
                n_err++;
            end else begin
                exp_r = echo_q.pop_front();
                check_field("echo_valid", exp_r.echo_valid, got.echo_valid);
                check_field("echo_char", exp_r.echo_char, got.echo_char);
                check_field("store_valid", exp_r.store_valid, got.store_valid);
                check_field("store_index", exp_r.store_index, got.store_index);
                check_field("store_char", exp_r.store_char, got.store_char);
                check_field("line_done", exp_r.line_done, got.line_done);
                check_field("line_length", exp_r.line_length, got.line_length);
                check_field("last", exp_r.last, got.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
